// ----- src/hmmfl_pkg.sv -----
// Package with types, codes, constants and the log-sum-exp correction table for the HMM forward block.
package hmmfl_pkg;

    localparam int STATES_MAX  = 8;
    localparam int STATE_W     = 3;
    localparam int CNT_W       = 4;
    localparam int FRAC_BITS   = 16;
    localparam int LOG_W       = 24;
    localparam int NLL_W       = 32;
    localparam int STEP_W      = 16;
    localparam int LSE_DEPTH   = 256;
    localparam int LSE_IDX_W   = $clog2(LSE_DEPTH);
    localparam int LSE_SHIFT   = FRAC_BITS + 4 - LSE_IDX_W;
    localparam int TRANS_DEPTH = STATES_MAX * STATES_MAX;
    localparam int TRANS_AW    = 2 * STATE_W;

    localparam logic signed [LOG_W-1:0] LOG_ZERO = {1'b1, {(LOG_W-1){1'b0}}};
    localparam logic signed [LOG_W-1:0] LOG_MAX  = {1'b0, {(LOG_W-1){1'b1}}};
    localparam logic [CNT_W-1:0] STATES_RESET = 4'd2;

    typedef enum logic [1:0] {
        OP_LOAD_TRANS = 2'd0,
        OP_LOAD_INIT  = 2'd1,
        OP_EMISSION   = 2'd2,
        OP_START      = 2'd3
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_EADD = 6'b000100,
        S_SUM  = 6'b001000,
        S_NORM = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    localparam logic [2:0] REG_STATES_IN_USE = 3'd0;

    typedef logic [LOG_W-1:0] t_lse_tab [LSE_DEPTH];

    // Unsigned quotient by long division, used only while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q, rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // exp(-r) in Q31 by a truncated Taylor series.
    function automatic longint unsigned exp_neg_q31(input longint unsigned r);
        longint          sum;
        longint unsigned term;
        sum  = longint'(64'd1 << 31);
        term = 64'd1 << 31;
        for (longint unsigned i = 1; i <= 24; i++) begin
            term = udiv64((term * r) >> 31, i);
            if (i[0]) sum = sum - longint'(term);
            else      sum = sum + longint'(term);
        end
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    // ln(1+exp(-x)) for x in [0,16), rounded to FRAC_BITS fraction bits.
    function automatic t_lse_tab build_lse_tab();
        t_lse_tab        tab;
        longint unsigned e1, xq, n, y, z, z2, p, s, res;
        e1 = exp_neg_q31(64'd1 << 31);
        for (int k = 0; k < LSE_DEPTH; k++) begin
            xq = (longint'(k) << 35) >> LSE_IDX_W;
            n  = xq >> 31;
            y  = exp_neg_q31(xq & ((64'd1 << 31) - 64'd1));
            for (longint unsigned m = 0; m < n; m++) y = (y * e1) >> 31;
            z  = udiv64(y << 31, (64'd2 << 31) + y);
            z2 = (z * z) >> 31;
            p  = z;
            s  = 64'd0;
            for (longint unsigned i = 0; i < 20; i++) begin
                s = s + udiv64(p, 2 * i + 1);
                p = (p * z2) >> 31;
            end
            res    = 2 * s;
            tab[k] = LOG_W'((res + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
        end
        return tab;
    endfunction

    localparam t_lse_tab LSE_TAB = build_lse_tab();

endpackage

// ----- src/hmmfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hmmfl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/hmm_forward_log_likelihood.sv -----
// Top level of the log-domain scaled HMM forward recursion with saturating negative log-likelihood.
//
// Channel   Dir  Handshake               Contents
// s_*       in   s_tvalid / s_tready     tuser: operation; tdata: row, col, value
// m_*       out  m_tvalid / m_tready     tdata: neg_log_lik, step_index
// APB       in   psel/penable/pwrite     register 0 at byte 0: states_in_use
//
// A load or start item is accepted in the idle state without leaving it. An emission item on
// the first step passes through the emission add and the step sum; on later steps it first
// walks the S previous alphas through the transition RAM read and the single shared log-sum-exp
// unit. The last state of a step adds renormalisation of each alpha (if the step sum is log
// zero, all alphas are set to log zero instead). The input is not ready while an item is at work, and the final state
// of a step waits while a finished item still sits unaccepted in the output register.
// Reset is synchronous and active low; it clears control state and the alphas.
module hmm_forward_log_likelihood (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic [31:0] s_tdata,   // [2:0] row, [5:3] col, [29:6] value, [31:30] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] neg_log_lik, [47:32] step_index
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = hmmfl_pkg::LOG_W;
    localparam int NW = hmmfl_pkg::NLL_W;
    localparam int SW = hmmfl_pkg::STATE_W;
    localparam int CW = hmmfl_pkg::CNT_W;

    // Configuration register.
    logic [CW-1:0] r_states;
    logic [CW-1:0] w_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states <= hmmfl_pkg::STATES_RESET;
        end else if (psel && penable && pwrite && paddr == hmmfl_pkg::REG_STATES_IN_USE) begin
            r_states <= pwdata[CW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == hmmfl_pkg::REG_STATES_IN_USE) ? {{(32-CW){1'b0}}, r_states} : 32'd0;

    // A zero count behaves as one state, anything beyond the built maximum as the maximum.
    always_comb begin
        if (r_states == '0) begin
            w_s = CW'(1);
        end else if (r_states > CW'(hmmfl_pkg::STATES_MAX)) begin
            w_s = CW'(hmmfl_pkg::STATES_MAX);
        end else begin
            w_s = r_states;
        end
    end

    // Input fields.
    hmmfl_pkg::t_op        w_op;
    logic [SW-1:0]         w_row, w_col;
    logic signed [LW-1:0]  w_value;
    logic                  w_acc;

    assign w_op    = hmmfl_pkg::t_op'(s_tuser);
    assign w_row   = s_tdata[2:0];
    assign w_col   = s_tdata[5:3];
    assign w_value = s_tdata[29:6];

    // Control and datapath state.
    hmmfl_pkg::t_state     r_state, n_state;
    logic [SW-1:0]         r_pos;
    logic                  r_first;
    logic signed [LW-1:0]  r_ssum;
    logic signed [NW-1:0]  r_nll;
    logic [15:0]           r_steps;
    logic signed [LW-1:0]  r_alpha [hmmfl_pkg::STATES_MAX];
    logic signed [LW-1:0]  r_new   [hmmfl_pkg::STATES_MAX];
    logic signed [LW-1:0]  r_init  [hmmfl_pkg::STATES_MAX];
    logic signed [LW-1:0]  r_v;
    logic signed [LW-1:0]  r_acc;
    logic signed [LW-1:0]  r_a;
    logic signed [LW-1:0]  r_term;
    logic [CW-1:0]         r_cnt;
    logic                  r_v1, r_v2;
    logic [SW-1:0]         r_idx1;
    logic                  r_out_valid;
    logic [47:0]           r_out_data;

    assign s_tready = (r_state == hmmfl_pkg::S_IDLE);
    assign w_acc    = s_tvalid && s_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // Transition store.
    logic [LW-1:0] w_trans;
    logic          w_issue;

    hmmfl_ram #(
        .WIDTH (LW),
        .DEPTH (hmmfl_pkg::TRANS_DEPTH)
    ) u_trans (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_op == hmmfl_pkg::OP_LOAD_TRANS),
        .i_waddr ({w_row, w_col}),
        .i_wdata (w_value),
        .i_raddr ({r_cnt[SW-1:0], r_pos}),
        .o_rdata (w_trans)
    );

    assign w_issue = (r_state == hmmfl_pkg::S_MAC) && (r_cnt < w_s);

    // Shared log-domain adder: any log-zero operand gives log zero, otherwise saturate.
    logic signed [LW-1:0] w_la_a, w_la_b, w_la_y;
    logic signed [LW:0]   w_la_sum;

    always_comb begin
        if (r_state == hmmfl_pkg::S_MAC) begin
            w_la_a = r_alpha[r_idx1];
            w_la_b = w_trans;
        end else begin
            w_la_a = r_first ? r_init[r_pos] : r_acc;
            w_la_b = r_v;
        end
        w_la_sum = {w_la_a[LW-1], w_la_a} + {w_la_b[LW-1], w_la_b};
        if (w_la_a == hmmfl_pkg::LOG_ZERO || w_la_b == hmmfl_pkg::LOG_ZERO) begin
            w_la_y = hmmfl_pkg::LOG_ZERO;
        end else if (w_la_sum < $signed({hmmfl_pkg::LOG_ZERO[LW-1], hmmfl_pkg::LOG_ZERO})) begin
            w_la_y = hmmfl_pkg::LOG_ZERO;
        end else if (w_la_sum > $signed({1'b0, hmmfl_pkg::LOG_MAX})) begin
            w_la_y = hmmfl_pkg::LOG_MAX;
        end else begin
            w_la_y = w_la_sum[LW-1:0];
        end
    end

    // Shared log-sum-exp unit: maximum plus the table correction for the difference.
    logic signed [LW-1:0] w_lse_a, w_lse_b, w_lse_y, w_hi, w_lo;
    logic [LW-1:0]        w_d, w_k;
    logic [LW:0]          w_hsum;

    always_comb begin
        if (r_state == hmmfl_pkg::S_MAC) begin
            w_lse_a = r_acc;
            w_lse_b = r_term;
        end else begin
            w_lse_a = r_ssum;
            w_lse_b = r_a;
        end
        w_hi   = (w_lse_a > w_lse_b) ? w_lse_a : w_lse_b;
        w_lo   = (w_lse_a > w_lse_b) ? w_lse_b : w_lse_a;
        w_d    = w_hi - w_lo;
        w_k    = w_d >> hmmfl_pkg::LSE_SHIFT;
        w_hsum = {1'b0, w_hi} + {1'b0, hmmfl_pkg::LSE_TAB[w_k[hmmfl_pkg::LSE_IDX_W-1:0]]};
        if (w_lse_a == hmmfl_pkg::LOG_ZERO) begin
            w_lse_y = w_lse_b;
        end else if (w_lse_b == hmmfl_pkg::LOG_ZERO) begin
            w_lse_y = w_lse_a;
        end else if (w_k >= LW'(hmmfl_pkg::LSE_DEPTH)) begin
            w_lse_y = w_hi;
        end else if (w_hi >= 0 && w_hsum[LW-1]) begin
            // A positive maximum plus the correction ran past the largest code.
            w_lse_y = hmmfl_pkg::LOG_MAX;
        end else begin
            w_lse_y = w_hsum[LW-1:0];
        end
    end

    // Renormalisation of one alpha by the step sum.
    logic signed [LW-1:0] w_nv, w_norm;
    logic signed [LW:0]   w_ndiff;

    always_comb begin
        w_nv    = r_new[r_cnt[SW-1:0]];
        w_ndiff = {w_nv[LW-1], w_nv} - {r_ssum[LW-1], r_ssum};
        if (w_nv == hmmfl_pkg::LOG_ZERO) begin
            w_norm = hmmfl_pkg::LOG_ZERO;
        end else if (w_ndiff < $signed({hmmfl_pkg::LOG_ZERO[LW-1], hmmfl_pkg::LOG_ZERO})) begin
            w_norm = hmmfl_pkg::LOG_ZERO;
        end else if (w_ndiff > $signed({1'b0, hmmfl_pkg::LOG_MAX})) begin
            w_norm = hmmfl_pkg::LOG_MAX;
        end else begin
            w_norm = w_ndiff[LW-1:0];
        end
    end

    // Likelihood update at the end of a step.
    logic signed [NW:0]   w_nsub;
    logic signed [NW-1:0] w_nll_next;
    logic [15:0]          w_steps_next;
    logic                 w_done_go;

    always_comb begin
        w_nsub = {r_nll[NW-1], r_nll} - (NW+1)'(r_ssum);
        if (r_ssum == hmmfl_pkg::LOG_ZERO) begin
            w_nll_next = {1'b0, {(NW-1){1'b1}}};
        end else if (w_nsub > $signed({2'b00, {(NW-1){1'b1}}})) begin
            w_nll_next = {1'b0, {(NW-1){1'b1}}};
        end else if (w_nsub < $signed({2'b11, {(NW-1){1'b0}}})) begin
            w_nll_next = {1'b1, {(NW-1){1'b0}}};
        end else begin
            w_nll_next = w_nsub[NW-1:0];
        end
        w_steps_next = (r_steps == 16'hFFFF) ? r_steps : r_steps + 16'd1;
        w_done_go    = (r_state == hmmfl_pkg::S_DONE) && (!r_out_valid || m_tready);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hmmfl_pkg::S_IDLE: begin
                if (w_acc && w_op == hmmfl_pkg::OP_EMISSION) begin
                    n_state = r_first ? hmmfl_pkg::S_EADD : hmmfl_pkg::S_MAC;
                end
            end
            hmmfl_pkg::S_MAC: begin
                if (!w_issue && !r_v1 && !r_v2) n_state = hmmfl_pkg::S_EADD;
            end
            hmmfl_pkg::S_EADD: n_state = hmmfl_pkg::S_SUM;
            hmmfl_pkg::S_SUM: begin
                if ({1'b0, r_pos} + CW'(1) < w_s) n_state = hmmfl_pkg::S_IDLE;
                else                               n_state = hmmfl_pkg::S_NORM;
            end
            hmmfl_pkg::S_NORM: begin
                if (r_ssum == hmmfl_pkg::LOG_ZERO || r_cnt >= w_s) n_state = hmmfl_pkg::S_DONE;
            end
            hmmfl_pkg::S_DONE: begin
                if (w_done_go) n_state = hmmfl_pkg::S_IDLE;
            end
            default: n_state = hmmfl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hmmfl_pkg::S_IDLE;
            r_pos       <= '0;
            r_first     <= 1'b1;
            r_ssum      <= hmmfl_pkg::LOG_ZERO;
            r_nll       <= '0;
            r_steps     <= '0;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < hmmfl_pkg::STATES_MAX; i++) begin
                r_alpha[i] <= '0;
                r_new[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_done_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                hmmfl_pkg::S_IDLE: begin
                    r_cnt <= '0;
                    r_acc <= hmmfl_pkg::LOG_ZERO;
                    if (w_acc && w_op == hmmfl_pkg::OP_START) begin
                        r_first <= 1'b1;
                        r_nll   <= '0;
                        r_steps <= '0;
                        r_pos   <= '0;
                        r_ssum  <= hmmfl_pkg::LOG_ZERO;
                    end
                end
                hmmfl_pkg::S_MAC: begin
                    // Three-deep walk: RAM read, log add, log-sum-exp into the accumulator.
                    if (w_issue) r_cnt <= r_cnt + CW'(1);
                    r_v1   <= w_issue;
                    r_idx1 <= r_cnt[SW-1:0];
                    r_v2   <= r_v1;
                    if (r_v1) r_term <= w_la_y;
                    if (r_v2) r_acc <= w_lse_y;
                end
                hmmfl_pkg::S_EADD: begin
                    r_a <= w_la_y;
                end
                hmmfl_pkg::S_SUM: begin
                    r_new[r_pos] <= r_a;
                    r_ssum       <= w_lse_y;
                    r_cnt        <= '0;
                    if ({1'b0, r_pos} + CW'(1) < w_s) r_pos <= r_pos + SW'(1);
                end
                hmmfl_pkg::S_NORM: begin
                    if (r_ssum == hmmfl_pkg::LOG_ZERO) begin
                        for (int i = 0; i < hmmfl_pkg::STATES_MAX; i++) begin
                            r_alpha[i] <= hmmfl_pkg::LOG_ZERO;
                        end
                    end else if (r_cnt < w_s) begin
                        r_alpha[r_cnt[SW-1:0]] <= w_norm;
                        r_cnt                  <= r_cnt + CW'(1);
                    end
                end
                hmmfl_pkg::S_DONE: begin
                    if (w_done_go) begin
                        r_nll       <= w_nll_next;
                        r_steps     <= w_steps_next;
                        r_first     <= 1'b0;
                        r_pos       <= '0;
                        r_ssum      <= hmmfl_pkg::LOG_ZERO;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_op == hmmfl_pkg::OP_LOAD_INIT) r_init[w_col] <= w_value;
        if (w_acc && w_op == hmmfl_pkg::OP_EMISSION)  r_v <= w_value;
        if (w_done_go) r_out_data <= {w_steps_next, w_nll_next};
    end

`ifndef NO_ASSERTIONS
    a_emit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == hmmfl_pkg::OP_EMISSION) |=> (r_state != hmmfl_pkg::S_IDLE))
        else $error("emission item did not start the sequencer");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hmmfl_pkg::S_DONE && r_out_valid && !m_tready)
        |=> (r_state == hmmfl_pkg::S_DONE))
        else $error("finished step overwrote an untaken result");

    a_pipe_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> (r_state == hmmfl_pkg::S_MAC))
        else $error("walk pipeline busy outside the walk");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hmmfl_pkg::S_MAC) |-> (r_cnt <= CW'(hmmfl_pkg::STATES_MAX)))
        else $error("walk counter ran past the state count");
`endif

endmodule
